### rtl/core/etds_pkg.sv
// Shared constants, widths and rounding helpers for the engine torque drivetrain step unit.
`default_nettype none

package etds_pkg;

  // Stream and configuration port widths.
  localparam int unsigned InDataW  = 184;
  localparam int unsigned OutDataW = 128;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 48;

  // Datapath widths of the shared multiplier and the accumulator.
  localparam int unsigned MulAW = 36;
  localparam int unsigned MulBW = 33;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned AccW  = 72;

  // Fixed-point constants.
  localparam int Q16One       = 65536;
  localparam int FilterFactor = 24109;
  localparam int FilterRest   = Q16One - FilterFactor;
  localparam int WrelCap      = 8388608;

  // Division of peak torque by ten as a reciprocal multiply, exact for 32-bit operands.
  localparam logic [MulBW-1:0] FloorRecip = MulBW'(64'hCCCC_CCCD);
  localparam int unsigned      FloorShift = 35;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFrontTraction = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgRearTraction  = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgTorqueAtZero  = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgTorqueMax     = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgSpeedTorqMax  = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgPowerMax      = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgSpeedPowMax   = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgSpeedZeroTorq = 4'd7;

  // Arithmetic right shift that rounds to nearest, ties away from zero.
  function automatic logic signed [AccW-1:0] round_shift(input logic signed [AccW-1:0] x,
                                                          input int unsigned n);
    logic signed [AccW-1:0] half;
    logic signed [AccW-1:0] sum;
    half = AccW'(1) <<< (n - 1);
    sum  = x + half - $signed({{(AccW-1){1'b0}}, x[AccW-1]});
    return sum >>> n;
  endfunction

  // Saturate a wide signed value to signed 32 bit.
  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] x);
    logic signed [31:0] r;
    if (x > $signed(AccW'(64'h7FFF_FFFF))) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -$signed(AccW'(64'h8000_0000))) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/engine_torque_drivetrain_step_unit.sv
// Top level: axle speed filter, engine torque curve and torque split on one shared datapath.
// The curve piece follows engine speed: below zero, rising quadratic, cubic, or above peak power
// speed; each item makes up to three divisions on the bit-serial divider.
// One item is in work at a time: the next transaction is taken in the cycle after the result
// is registered, and a result held back by the sink stalls the input.
// Reset (async, active low) loads the register defaults and clears the filtered speed.
`default_nettype none

module engine_torque_drivetrain_step_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write channel.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [etds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [etds_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input stream.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: wheel_speed_front_left, wheel_speed_front_right,
  // wheel_speed_rear_left, wheel_speed_rear_right, throttle, gear_ratio, zero fill.
  input  wire logic [etds_pkg::InDataW-1:0]   s_axis_tdata,
  // Output stream.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // Fields from bit 0: axle_torque, front_wheel_torque, rear_wheel_torque, axle_speed.
  output logic [etds_pkg::OutDataW-1:0]       m_axis_tdata
);

  import etds_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE, ST_CUR1, ST_CUR2, ST_CUR3, ST_CUR4, ST_FLT1, ST_FLT2, ST_FLT3, ST_FLT4,
    ST_WE1, ST_WE2, ST_SEL, ST_DIV,
    ST_P2_WREL, ST_P2_1, ST_P2_2, ST_P2_3, ST_P2_4,
    ST_CB_PW, ST_CB_WREL, ST_CB_Q, ST_CB_1, ST_CB_2, ST_CB_3, ST_CB_4, ST_CB_5,
    ST_CB_6, ST_CB_7, ST_CB_8, ST_CB_9,
    ST_EL_PW, ST_EL_WREL, ST_EL_FL, ST_EL_1, ST_EL_2, ST_EL_3, ST_EL_4, ST_EL_5, ST_EL_6,
    ST_SATM, ST_MT1, ST_MT2, ST_AX1, ST_AX2, ST_WH1, ST_WH2, ST_WH3
  } state_e;

  // Configuration registers.
  logic [16:0]        ft_q, rt_q;
  logic signed [31:0] t0_q;
  logic [30:0]        tm_q, wm_q, wp_q, wz_q;
  logic [47:0]        pmax_q;

  // Filter state and latched item.
  logic signed [31:0] filt_q;
  logic signed [32:0] sf_q, sr_q;
  logic [16:0]        thr_q;
  logic signed [31:0] ratio_q;

  // Working registers.
  state_e                  state_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [35:0]      cur_q;
  logic signed [48:0]      we_q;
  logic [30:0]             pw_q;
  logic signed [24:0]      wrel_q;
  logic [15:0]             q_q;
  logic signed [31:0]      w2_q, w3_q;
  logic signed [35:0]      a_q, b_q;
  logic signed [31:0]      floor_q, m_q, mt_q, axle_q, fw_q;
  logic [OutDataW-1:0]     out_data_q;
  logic                    out_valid_q;

  // Bit-serial divider.
  logic [63:0] dv_num_q;
  logic [30:0] dv_rem_q, dv_den_q;
  logic [5:0]  dv_cnt_q;
  state_e      dv_ret_q;

  // Shared multiplier.
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] product, p_q;

  // Derived values.
  logic signed [AccW-1:0] p_ext, rnd16, rnd17;
  logic                   we_lt_wm, we_lt_wp;
  logic [31:0]            wm_minus_we, we_minus_wm;
  logic signed [48:0]     we_minus_wp;
  logic [30:0]            dw, dz_den, pw_den, pw_sat;
  logic signed [31:0]     dz;
  logic [32:0]            tm3;
  logic [31:0]            rem_sh;
  logic                   rem_ge;
  logic [30:0]            rem_nx;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Rounded views of the registered product.
  assign p_ext = {{(AccW-ProdW){p_q[ProdW-1]}}, p_q};
  assign rnd16 = round_shift(p_ext, 16);
  assign rnd17 = round_shift(p_ext, 17);

  // Curve piece selection and divider operands.
  assign we_lt_wm    = we_q < $signed({18'd0, wm_q});
  assign we_lt_wp    = we_q < $signed({18'd0, wp_q});
  assign wm_minus_we = {1'b0, wm_q} - {1'b0, we_q[30:0]};
  assign we_minus_wm = we_q[31:0] - {1'b0, wm_q};
  assign we_minus_wp = we_q - $signed({18'd0, wp_q});
  assign dw          = wp_q - wm_q;
  assign dz          = $signed({1'b0, wz_q}) - $signed({1'b0, wp_q});
  assign dz_den      = (dz[31] || dz == 32'sd0) ? 31'd1 : dz[30:0];
  assign pw_den      = (wp_q == 31'd0) ? 31'd1 : wp_q;
  assign pw_sat      = (dv_num_q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dv_num_q[30:0];
  assign tm3         = {1'b0, tm_q, 1'b0} + {2'b0, tm_q};

  // One restoring division step.
  assign rem_sh = {dv_rem_q, dv_num_q[63]};
  assign rem_ge = rem_sh >= {1'b0, dv_den_q};
  assign rem_nx = rem_ge ? 31'(rem_sh - {1'b0, dv_den_q}) : rem_sh[30:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_CUR1: begin
        mul_a = {19'd0, ft_q};
        mul_b = sf_q;
      end
      ST_CUR2: begin
        mul_a = {19'd0, rt_q};
        mul_b = sr_q;
      end
      ST_FLT1: begin
        mul_a = {{4{filt_q[31]}}, filt_q};
        mul_b = MulBW'(FilterFactor);
      end
      ST_FLT2: begin
        mul_a = cur_q;
        mul_b = MulBW'(FilterRest);
      end
      ST_WE1: begin
        mul_a = {{4{filt_q[31]}}, filt_q};
        mul_b = {ratio_q[31], ratio_q};
      end
      ST_P2_1, ST_CB_4, ST_EL_1: begin
        mul_a = {{11{wrel_q[24]}}, wrel_q};
        mul_b = {{8{wrel_q[24]}}, wrel_q};
      end
      ST_P2_3, ST_CB_7: begin
        mul_a = a_q;
        mul_b = {w2_q[31], w2_q};
      end
      ST_CB_1: begin
        mul_a = {5'd0, pw_q};
        mul_b = MulBW'(3 * Q16One) + {17'd0, q_q};
      end
      ST_CB_2: begin
        mul_a = {5'd0, pw_q};
        mul_b = MulBW'(2 * Q16One) + {17'd0, q_q};
      end
      ST_CB_6: begin
        mul_a = {{4{w2_q[31]}}, w2_q};
        mul_b = {{8{wrel_q[24]}}, wrel_q};
      end
      ST_CB_8: begin
        mul_a = b_q;
        mul_b = {w3_q[31], w3_q};
      end
      ST_EL_WREL: begin
        mul_a = {5'd0, tm_q};
        mul_b = FloorRecip;
      end
      ST_EL_4: begin
        mul_a = {5'd0, pw_q};
        mul_b = {w3_q[31], w3_q};
      end
      ST_MT1: begin
        mul_a = {{4{m_q[31]}}, m_q};
        mul_b = {16'd0, thr_q};
      end
      ST_AX1: begin
        mul_a = {{4{mt_q[31]}}, mt_q};
        mul_b = {ratio_q[31], ratio_q};
      end
      ST_WH1: begin
        mul_a = {19'd0, ft_q};
        mul_b = {axle_q[31], axle_q};
      end
      // The rear product stays on the multiplier while the result waits.
      ST_WH2, ST_WH3: begin
        mul_a = {19'd0, rt_q};
        mul_b = {axle_q[31], axle_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // Product register after the multiplier.
  always_ff @(posedge clk_i) begin
    p_q <= product;
  end

  // Sequencer, configuration registers, datapath registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ft_q        <= 17'd32768;
      rt_q        <= 17'd32768;
      t0_q        <= '0;
      tm_q        <= '0;
      wm_q        <= 31'd65536;
      pmax_q      <= '0;
      wp_q        <= 31'd131072;
      wz_q        <= 31'd196608;
      filt_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      sf_q        <= '0;
      sr_q        <= '0;
      thr_q       <= '0;
      ratio_q     <= '0;
      acc_q       <= '0;
      cur_q       <= '0;
      we_q        <= '0;
      pw_q        <= '0;
      wrel_q      <= '0;
      q_q         <= '0;
      w2_q        <= '0;
      w3_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      floor_q     <= '0;
      m_q         <= '0;
      mt_q        <= '0;
      axle_q      <= '0;
      fw_q        <= '0;
      dv_num_q    <= '0;
      dv_rem_q    <= '0;
      dv_den_q    <= '0;
      dv_cnt_q    <= '0;
      dv_ret_q    <= ST_IDLE;
    end else begin
      // Configuration transaction.
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgFrontTraction: ft_q   <= cfg_data_i[16:0];
          CfgRearTraction:  rt_q   <= cfg_data_i[16:0];
          CfgTorqueAtZero:  t0_q   <= cfg_data_i[31:0];
          CfgTorqueMax:     tm_q   <= cfg_data_i[30:0];
          CfgSpeedTorqMax:  wm_q   <= cfg_data_i[30:0];
          CfgPowerMax:      pmax_q <= cfg_data_i[47:0];
          CfgSpeedPowMax:   wp_q   <= cfg_data_i[30:0];
          CfgSpeedZeroTorq: wz_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      // The result leaves when the sink takes it, unless a new one replaces it.
      if (out_valid_q && m_axis_tready && state_q != ST_WH3) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            sf_q    <= {s_axis_tdata[31], s_axis_tdata[31:0]}
                     + {s_axis_tdata[63], s_axis_tdata[63:32]};
            sr_q    <= {s_axis_tdata[95], s_axis_tdata[95:64]}
                     + {s_axis_tdata[127], s_axis_tdata[127:96]};
            thr_q   <= s_axis_tdata[144:128];
            ratio_q <= s_axis_tdata[176:145];
            state_q <= ST_CUR1;
          end
        end

        // Traction-weighted axle speed.
        ST_CUR1: state_q <= ST_CUR2;
        ST_CUR2: begin
          acc_q   <= p_ext;
          state_q <= ST_CUR3;
        end
        ST_CUR3: begin
          acc_q   <= acc_q + p_ext;
          state_q <= ST_CUR4;
        end
        ST_CUR4: begin
          cur_q   <= 36'(round_shift(acc_q, 17));
          state_q <= ST_FLT1;
        end

        // First-order low-pass.
        ST_FLT1: state_q <= ST_FLT2;
        ST_FLT2: begin
          acc_q   <= p_ext;
          state_q <= ST_FLT3;
        end
        ST_FLT3: begin
          acc_q   <= acc_q + p_ext;
          state_q <= ST_FLT4;
        end
        ST_FLT4: begin
          filt_q  <= sat32(round_shift(acc_q, 16));
          state_q <= ST_WE1;
        end

        // Engine speed.
        ST_WE1: state_q <= ST_WE2;
        ST_WE2: begin
          we_q    <= 49'(rnd16);
          state_q <= ST_SEL;
        end

        // Pick the curve piece and launch its first division; below zero engine speed none is needed.
        ST_SEL: begin
          if (we_q[48]) begin
            m_q     <= t0_q;
            state_q <= ST_MT1;
          end else if (we_lt_wm) begin
            dv_num_q <= {16'd0, wm_minus_we, 16'd0};
            dv_den_q <= wm_q;
            dv_rem_q <= '0;
            dv_cnt_q <= '1;
            dv_ret_q <= ST_P2_WREL;
            state_q  <= ST_DIV;
          end else begin
            dv_num_q <= {pmax_q, 16'd0};
            dv_den_q <= pw_den;
            dv_rem_q <= '0;
            dv_cnt_q <= '1;
            dv_ret_q <= we_lt_wp ? ST_CB_PW : ST_EL_PW;
            state_q  <= ST_DIV;
          end
        end

        // Divider iterations, one quotient bit per cycle.
        ST_DIV: begin
          dv_rem_q <= rem_nx;
          dv_num_q <= {dv_num_q[62:0], rem_ge};
          dv_cnt_q <= dv_cnt_q - 6'd1;
          if (dv_cnt_q == 6'd0) begin
            state_q <= dv_ret_q;
          end
        end

        // Rising quadratic below peak torque speed.
        ST_P2_WREL: begin
          wrel_q  <= 25'd0 - dv_num_q[24:0];
          a_q     <= {5'd0, tm_q} - {{4{t0_q[31]}}, t0_q};
          state_q <= ST_P2_1;
        end
        ST_P2_1: state_q <= ST_P2_2;
        ST_P2_2: begin
          w2_q    <= 32'(rnd16);
          state_q <= ST_P2_3;
        end
        ST_P2_3: state_q <= ST_P2_4;
        ST_P2_4: begin
          acc_q   <= $signed({41'd0, tm_q}) - rnd16;
          state_q <= ST_SATM;
        end

        // Cubic between peak torque and peak power speed.
        ST_CB_PW: begin
          pw_q     <= pw_sat;
          dv_num_q <= {16'd0, we_minus_wm, 16'd0};
          dv_den_q <= dw;
          dv_rem_q <= '0;
          dv_cnt_q <= '1;
          dv_ret_q <= ST_CB_WREL;
          state_q  <= ST_DIV;
        end
        ST_CB_WREL: begin
          wrel_q   <= dv_num_q[24:0];
          dv_num_q <= {17'd0, dw, 16'd0};
          dv_den_q <= wp_q;
          dv_rem_q <= '0;
          dv_cnt_q <= '1;
          dv_ret_q <= ST_CB_Q;
          state_q  <= ST_DIV;
        end
        ST_CB_Q: begin
          q_q     <= dv_num_q[15:0];
          state_q <= ST_CB_1;
        end
        ST_CB_1: state_q <= ST_CB_2;
        ST_CB_2: begin
          acc_q   <= rnd16;
          state_q <= ST_CB_3;
        end
        ST_CB_3: begin
          a_q     <= acc_q[35:0] - {3'd0, tm3};
          acc_q   <= rnd16;
          state_q <= ST_CB_4;
        end
        ST_CB_4: begin
          b_q     <= acc_q[35:0] - {4'd0, tm_q, 1'b0};
          state_q <= ST_CB_5;
        end
        ST_CB_5: begin
          w2_q    <= 32'(rnd16);
          state_q <= ST_CB_6;
        end
        ST_CB_6: state_q <= ST_CB_7;
        ST_CB_7: begin
          w3_q    <= 32'(rnd16);
          state_q <= ST_CB_8;
        end
        ST_CB_8: begin
          acc_q   <= $signed({41'd0, tm_q}) + rnd16;
          state_q <= ST_CB_9;
        end
        ST_CB_9: begin
          acc_q   <= acc_q - rnd16;
          state_q <= ST_SATM;
        end

        // Falling quadratic above peak power speed.
        ST_EL_PW: begin
          pw_q     <= pw_sat;
          dv_num_q <= {we_minus_wp[47:0], 16'd0};
          dv_den_q <= dz_den;
          dv_rem_q <= '0;
          dv_cnt_q <= '1;
          dv_ret_q <= ST_EL_WREL;
          state_q  <= ST_DIV;
        end
        ST_EL_WREL: begin
          wrel_q  <= (dv_num_q > 64'(WrelCap)) ? 25'(WrelCap) : dv_num_q[24:0];
          state_q <= ST_EL_FL;
        end
        // The torque floor is minus a tenth of peak torque.
        ST_EL_FL: begin
          floor_q <= 32'd0 - {1'b0, p_q[FloorShift+30:FloorShift]};
          state_q <= ST_EL_1;
        end
        ST_EL_1: state_q <= ST_EL_2;
        ST_EL_2: begin
          w2_q    <= 32'(rnd16);
          state_q <= ST_EL_3;
        end
        ST_EL_3: begin
          w3_q    <= 32'(Q16One) - w2_q;
          state_q <= ST_EL_4;
        end
        ST_EL_4: state_q <= ST_EL_5;
        ST_EL_5: begin
          acc_q   <= rnd16;
          state_q <= ST_EL_6;
        end
        ST_EL_6: begin
          if (acc_q < $signed({{(AccW-32){floor_q[31]}}, floor_q})) begin
            acc_q <= $signed({{(AccW-32){floor_q[31]}}, floor_q});
          end
          state_q <= ST_SATM;
        end

        // Throttle, ratio and per-wheel split.
        ST_SATM: begin
          m_q     <= sat32(acc_q);
          state_q <= ST_MT1;
        end
        ST_MT1: state_q <= ST_MT2;
        ST_MT2: begin
          mt_q    <= sat32(rnd16);
          state_q <= ST_AX1;
        end
        ST_AX1: state_q <= ST_AX2;
        ST_AX2: begin
          axle_q  <= sat32(rnd16);
          state_q <= ST_WH1;
        end
        ST_WH1: state_q <= ST_WH2;
        ST_WH2: begin
          fw_q    <= sat32(rnd17);
          state_q <= ST_WH3;
        end
        ST_WH3: begin
          // Hold here until the output register is free.
          if (!out_valid_q || m_axis_tready) begin
            out_data_q  <= {filt_q, sat32(rnd17), fw_q, axle_q};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
